[src/tccs_pkg.sv]
// Shared types, codes and defaults for the text console cursor/scroll core.
// No dependencies; the front end, queue, back end, top level and bench import this package.
`timescale 1ns / 1ps

package tccs_pkg;

   localparam int SCREEN_WIDTH_DEF  = 80;
   localparam int SCREEN_HEIGHT_DEF = 25;
   localparam int TAB_SPACES_DEF    = 4;
   localparam int QUEUE_DEPTH       = 2;

   localparam int CURSOR_ROW_W = 5;
   localparam int CURSOR_COL_W = 7;
   localparam int CELL_W       = 16;

   localparam logic ACTION_PUT  = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] COLOR_AT_RESET = 8'd2;

   typedef struct packed {
      logic                    action;
      logic [7:0]              char_code;
      logic [CURSOR_ROW_W-1:0] read_row;
      logic [CURSOR_COL_W-1:0] read_col;
   } req_type;

   typedef struct packed {
      logic [7:0]              cell_char;
      logic [7:0]              cell_color;
      logic [CURSOR_ROW_W-1:0] cursor_row;
      logic [CURSOR_COL_W-1:0] cursor_col;
   } rsp_type;

   typedef struct packed {
      logic [7:0] color;
      logic [7:0] ch;
   } cell_type;

   typedef enum logic [2:0] {
      OP_PLAIN,
      OP_NEWLINE,
      OP_TAB,
      OP_BACKSPACE,
      OP_READ,
      OP_READ_OUT
   } op_kind_type;

   typedef struct packed {
      op_kind_type             kind;
      logic [7:0]              char_code;
      logic [CURSOR_ROW_W-1:0] read_row;
      logic [CURSOR_COL_W-1:0] read_col;
   } op_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL
   } back_state_type;

endpackage

[src/tccs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tccs_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/tccs_front.sv]
// Front end: takes request words, decodes them into operations and hands them to the queue.
// Depends on tccs_pkg.
`timescale 1ns / 1ps

module tccs_front
   import tccs_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_type          req_item,
   input  logic             clearing,
   input  queue_status_type q_status,
   output logic             push,
   output op_type           push_op,
   output logic             busy
);

   logic   valid_ff, valid_in;
   op_type op_ff, op_in;
   logic   accept;
   op_type decoded;

   always_comb begin
      decoded.char_code = req_item.char_code;
      decoded.read_row  = req_item.read_row;
      decoded.read_col  = req_item.read_col;
      priority if (req_item.action == ACTION_READ) begin
         if ((16'(req_item.read_row) < 16'(SCREEN_HEIGHT)) &&
             (16'(req_item.read_col) < 16'(SCREEN_WIDTH))) begin
            decoded.kind = OP_READ;
         end else begin
            decoded.kind = OP_READ_OUT;
         end
      end else if (req_item.char_code == CH_NEWLINE) begin
         decoded.kind = OP_NEWLINE;
      end else if (req_item.char_code == CH_TAB) begin
         decoded.kind = OP_TAB;
      end else if (req_item.char_code == CH_BACKSPACE) begin
         decoded.kind = OP_BACKSPACE;
      end else begin
         decoded.kind = OP_PLAIN;
      end
   end

   assign push   = valid_ff && !q_status.full;
   assign busy   = clearing || (valid_ff && q_status.full);
   assign accept = start && !busy;

   always_comb begin
      valid_in = valid_ff;
      op_in    = op_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         op_in    = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      op_ff <= op_in;
   end

   assign push_op = op_ff;

endmodule

[src/tccs_queue.sv]
// Short FIFO of decoded operations between the front end and the back end.
// Depends on tccs_pkg.
`timescale 1ns / 1ps

module tccs_queue
   import tccs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  op_type           push_op,
   input  logic             pop,
   output op_type           head,
   output queue_status_type q_status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

[src/tccs_back.sv]
// Back end: owns the cursor and the row-rotation offset, drives the screen RAM and the result word.
// Depends on tccs_pkg; the screen RAM sits beside it in the top level.
`timescale 1ns / 1ps

module tccs_back
   import tccs_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int TAB_SPACES    = TAB_SPACES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [7:0]                             text_color,
   input  op_type                                 head,
   input  queue_status_type                       q_status,
   output logic                                   pop,
   output logic                                   clearing,
   output logic                                   ram_wr_en,
   output logic [$clog2(SCREEN_WIDTH*SCREEN_HEIGHT)-1:0] ram_wr_addr,
   output logic [CELL_W-1:0]                      ram_wr_data,
   output logic                                   ram_rd_en,
   output logic [$clog2(SCREEN_WIDTH*SCREEN_HEIGHT)-1:0] ram_rd_addr,
   input  logic [CELL_W-1:0]                      ram_rd_data,
   output logic                                   rsp_strobe,
   output rsp_type                                rsp_item
);

   localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int ROW_W      = $clog2(SCREEN_HEIGHT);
   localparam int COL_W      = $clog2(SCREEN_WIDTH);
   localparam int TAB_W      = $clog2(TAB_SPACES + 1);

   back_state_type    state_ff, state_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [TAB_W-1:0]  cnt_ff, cnt_in;
   op_type            op_ff, op_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [ROW_W-1:0]  addr_row;
   logic [COL_W-1:0]  addr_col;
   logic [ROW_W:0]    row_sum;
   logic [ROW_W-1:0]  phys_row;
   logic [ADDR_W-1:0] cell_addr;
   logic [ROW_W-1:0]  bs_row;
   logic [COL_W-1:0]  bs_col;
   cell_type          wr_cell;
   logic [7:0]        put_char;
   logic              at_last_col;
   logic              at_last_row;
   logic [ROW_W-1:0]  top_next;

   assign at_last_col = (col_ff == COL_W'(SCREEN_WIDTH - 1));
   assign at_last_row = (row_ff == ROW_W'(SCREEN_HEIGHT - 1));
   assign top_next    = (top_ff == ROW_W'(SCREEN_HEIGHT - 1)) ? '0 : top_ff + 1'b1;
   assign put_char    = (op_ff.kind == OP_TAB) ? CH_SPACE : op_ff.char_code;

   // backspace target: step left, or wrap to the end of the row above, or stay at the origin
   always_comb begin
      bs_row = row_ff;
      bs_col = col_ff;
      if (col_ff != '0) begin
         bs_col = col_ff - 1'b1;
      end else if (row_ff != '0) begin
         bs_row = row_ff - 1'b1;
         bs_col = COL_W'(SCREEN_WIDTH - 1);
      end
   end

   // logical row to physical row through the rotation offset
   always_comb begin
      row_sum = (ROW_W+1)'(addr_row) + (ROW_W+1)'(top_ff);
      if (row_sum >= (ROW_W+1)'(SCREEN_HEIGHT)) begin
         row_sum = row_sum - (ROW_W+1)'(SCREEN_HEIGHT);
      end
      phys_row  = row_sum[ROW_W-1:0];
      cell_addr = ADDR_W'(phys_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(addr_col);
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      top_in       = top_ff;
      sweep_in     = sweep_ff;
      cnt_in       = cnt_ff;
      op_in        = op_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      addr_row     = row_ff;
      addr_col     = col_ff;
      wr_cell.color = text_color;
      wr_cell.ch    = CH_SPACE;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en     = 1'b1;
            wr_cell.color = COLOR_AT_RESET;
            if (sweep_ff == ADDR_W'(CELL_COUNT - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               op_in    = head;
               state_in = ST_EXEC;
               if (head.kind == OP_TAB) begin
                  cnt_in = TAB_W'(TAB_SPACES);
               end else if (head.kind == OP_PLAIN) begin
                  cnt_in = TAB_W'(1);
               end else begin
                  cnt_in = '0;
               end
            end
         end
         ST_EXEC: begin
            unique case (op_ff.kind)
               OP_READ: begin
                  addr_row  = ROW_W'(op_ff.read_row);
                  addr_col  = COL_W'(op_ff.read_col);
                  ram_rd_en = 1'b1;
                  state_in  = ST_READ;
               end
               OP_READ_OUT: begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
               OP_BACKSPACE: begin
                  addr_row     = bs_row;
                  addr_col     = bs_col;
                  ram_wr_en    = 1'b1;
                  row_in       = bs_row;
                  col_in       = bs_col;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
               OP_NEWLINE: begin
                  col_in = '0;
                  if (at_last_row) begin
                     top_in   = top_next;
                     sweep_in = '0;
                     state_in = ST_SCROLL;
                  end else begin
                     row_in       = row_ff + 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               OP_PLAIN, OP_TAB: begin
                  ram_wr_en  = 1'b1;
                  wr_cell.ch = put_char;
                  cnt_in     = cnt_ff - 1'b1;
                  if (at_last_col) begin
                     col_in = '0;
                     if (at_last_row) begin
                        top_in   = top_next;
                        sweep_in = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
                  if (state_in != ST_SCROLL && cnt_ff == TAB_W'(1)) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            // the new bottom row is the old top row; blank it one cell a cycle
            addr_col  = sweep_ff[COL_W-1:0];
            ram_wr_en = 1'b1;
            if (sweep_ff[COL_W-1:0] == COL_W'(SCREEN_WIDTH - 1)) begin
               sweep_in = '0;
               if (cnt_ff != '0) begin
                  state_in = ST_EXEC;
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_valid_in) begin
         rsp_in.cursor_row = CURSOR_ROW_W'(row_in);
         rsp_in.cursor_col = CURSOR_COL_W'(col_in);
         if (state_ff == ST_READ) begin
            rsp_in.cell_char  = ram_rd_data[7:0];
            rsp_in.cell_color = ram_rd_data[15:8];
         end else begin
            rsp_in.cell_char  = '0;
            rsp_in.cell_color = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         sweep_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         sweep_ff     <= sweep_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
   end

   assign clearing    = (state_ff == ST_CLEAR);
   assign ram_wr_addr = clearing ? sweep_ff : cell_addr;
   assign ram_wr_data = wr_cell;
   assign ram_rd_addr = cell_addr;
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_item    = rsp_ff;

endmodule

[src/text_console_cursor_scroll_core.sv]
// Top level of the text console core: front end, operation queue, back end, screen RAM,
// and the color register. Depends on tccs_pkg, tccs_front, tccs_queue, tccs_back, tccs_ram.
`timescale 1ns / 1ps

//  channel   ports                            handshake
//  request   start, busy, req_item            taken when start && !busy
//  result    rsp_strobe, rsp_item             one cycle per word, never held off
//  config    csr_wr_en, csr_wr_data           written when csr_wr_en is high
//
//  The back end pops one operation in idle and carries it out in its execute state; a
//  screen read also passes through the read state, a tab writes TAB_SPACES blank cells and
//  a scroll blanks the SCREEN_WIDTH cells of the new bottom row. The result word is
//  registered, so it appears in the cycle after the operation finishes. After reset the
//  screen RAM is swept once over all SCREEN_WIDTH * SCREEN_HEIGHT cells, with busy high.
//  Busy also rises when the front register and the queue are both full.

module text_console_cursor_scroll_core
   import tccs_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int TAB_SPACES    = TAB_SPACES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  req_type    req_item,
   output logic       busy,
   output logic       rsp_strobe,
   output rsp_type    rsp_item,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int CELL_COUNT  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int CELL_ADDR_W = $clog2(CELL_COUNT);

   logic [7:0]             text_color_ff;
   logic                   clearing;
   queue_status_type       q_status;
   logic                   push;
   op_type                 push_op;
   logic                   pop;
   op_type                 head;
   logic                   ram_wr_en;
   logic [CELL_ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0]      ram_wr_data;
   logic                   ram_rd_en;
   logic [CELL_ADDR_W-1:0] ram_rd_addr;
   logic [CELL_W-1:0]      ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= COLOR_AT_RESET;
      end else if (csr_wr_en) begin
         text_color_ff <= csr_wr_data;
      end
   end

   tccs_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .clearing (clearing),
      .q_status (q_status),
      .push     (push),
      .push_op  (push_op),
      .busy     (busy)
   );

   tccs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_op  (push_op),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   tccs_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .TAB_SPACES    (TAB_SPACES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .text_color  (text_color_ff),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .clearing    (clearing),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

   tccs_ram #(
      .DATA_W (CELL_W),
      .DEPTH  (CELL_COUNT)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // the back end always passes through idle between two results
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on two cycles in a row");

   // the screen sweep keeps input off right after reset
   assert property (@(posedge clock) (!reset && $past(reset)) |-> busy)
      else $error("input not held off after reset");

   // no result while the screen sweep runs
   assert property (@(posedge clock) disable iff (reset) clearing |-> !rsp_strobe)
      else $error("result during screen sweep");

   // the reported cursor row stays on the screen
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_item.cursor_row) < SCREEN_HEIGHT))
      else $error("cursor row beyond screen");

endmodule

[tb/text_console_cursor_scroll_core_tb.sv]
// Self-checking bench for text_console_cursor_scroll_core: a queued word driver, a result
// monitor and an in-bench screen/cursor predictor. Depends on tccs_pkg and the core RTL.
`timescale 1ns / 1ps

module text_console_cursor_scroll_core_tb;
   import tccs_pkg::*;

   localparam int COLS        = SCREEN_WIDTH_DEF;
   localparam int ROWS        = SCREEN_HEIGHT_DEF;
   localparam int TABS        = TAB_SPACES_DEF;
   localparam int CELLS       = COLS * ROWS;
   localparam int STALL_LIMIT = 10000;
   localparam int MAX_REPORTS = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   req_type    req_item = '0;
   logic       busy;
   logic       rsp_strobe;
   rsp_type    rsp_item;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;

   text_console_cursor_scroll_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Predicted console state
   cell_type    screen_model [CELLS];
   int unsigned cur_row = 0;
   int unsigned cur_col = 0;
   logic [7:0]  color_model = COLOR_AT_RESET;

   req_type pending_req[$];
   rsp_type expected_rsp[$];
   int      words_queued = 0;
   int      results_seen = 0;
   int      error_count = 0;
   int      idle_cycles = 0;

   initial begin
      for (int i = 0; i < CELLS; i++) begin
         screen_model[i].ch    = CH_SPACE;
         screen_model[i].color = COLOR_AT_RESET;
      end
   end

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void paint_cell(int unsigned col, int unsigned row, logic [7:0] ch);
      if (col < COLS && row < ROWS) begin
         screen_model[row * COLS + col].ch    = ch;
         screen_model[row * COLS + col].color = color_model;
      end
   endfunction

   function automatic void line_feed();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         cur_row = ROWS - 1;
         for (int i = 0; i + COLS < CELLS; i++)
            screen_model[i] = screen_model[i + COLS];
         for (int i = 0; i < COLS; i++)
            paint_cell(i, ROWS - 1, CH_SPACE);
      end
   endfunction

   function automatic void emit_glyph(logic [7:0] ch);
      paint_cell(cur_col, cur_row, ch);
      cur_col++;
      if (cur_col >= COLS)
         line_feed();
   endfunction

   // Apply one word to the predicted console and return the expected result
   function automatic rsp_type console_step(req_type w);
      rsp_type r;
      int      idx;
      r = '0;
      if (w.action == ACTION_PUT) begin
         case (w.char_code)
            CH_NEWLINE: line_feed();
            CH_TAB: begin
               for (int k = 0; k < TABS; k++)
                  emit_glyph(CH_SPACE);
            end
            CH_BACKSPACE: begin
               if (cur_col > 0) begin
                  cur_col--;
               end else if (cur_row > 0) begin
                  cur_row--;
                  cur_col = COLS - 1;
               end
               paint_cell(cur_col, cur_row, CH_SPACE);
            end
            default: emit_glyph(w.char_code);
         endcase
      end else if (int'(w.read_row) < ROWS && int'(w.read_col) < COLS) begin
         idx          = int'(w.read_row) * COLS + int'(w.read_col);
         r.cell_char  = screen_model[idx].ch;
         r.cell_color = screen_model[idx].color;
      end
      r.cursor_row = CURSOR_ROW_W'(cur_row);
      r.cursor_col = CURSOR_COL_W'(cur_col);
      return r;
   endfunction

   function automatic req_type put_word(logic [7:0] ch);
      req_type w;
      w.action    = ACTION_PUT;
      w.char_code = ch;
      w.read_row  = CURSOR_ROW_W'($urandom);
      w.read_col  = CURSOR_COL_W'($urandom);
      return w;
   endfunction

   function automatic req_type read_word(int unsigned row, int unsigned col);
      req_type w;
      w.action    = ACTION_READ;
      w.char_code = 8'($urandom);
      w.read_row  = CURSOR_ROW_W'(row);
      w.read_col  = CURSOR_COL_W'(col);
      return w;
   endfunction

   function automatic req_type random_word();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         return put_word(8'($urandom_range(32, 126)));
      else if (pick < 50)
         return put_word(8'($urandom_range(0, 255)));
      else if (pick < 58)
         return put_word(CH_NEWLINE);
      else if (pick < 63)
         return put_word(CH_TAB);
      else if (pick < 70)
         return put_word(CH_BACKSPACE);
      else if (pick < 97)
         return read_word($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
      else
         return read_word($urandom_range(0, 31), $urandom_range(0, 127));
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic queue_word(req_type w);
      pending_req.push_back(w);
      words_queued++;
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++)
         queue_word(random_word());
   endtask

   // Wait until every queued word has produced its result, then let the core settle
   task automatic wait_drained(int settle);
      do @(posedge clock); while (results_seen != words_queued);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_color(logic [7:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      color_model = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic flag_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // Driver
   int unsigned gap_left = 0;
   int unsigned steady_left = 0;
   bit          drain_hold = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
         drain_hold = 1'b0;
      end else begin
         if (start && !busy)
            expected_rsp.push_back(console_step(req_item));
         if (drain_hold && expected_rsp.size() == 0 && !(start && busy))
            drain_hold = 1'b0;
         if (start && busy) begin
            // hold the word until the core takes it
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_req.size() > 0 && !drain_hold) begin
            req_item <= pending_req.pop_front();
            start    <= 1'b1;
            if (steady_left > 0) begin
               steady_left--;
               gap_left = 0;
            end else begin
               gap_left = pick_gap();
               if ($urandom_range(0, 39) == 0)
                  steady_left = $urandom_range(20, 80);
            end
            if ($urandom_range(0, 59) == 0)
               drain_hold = 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (expected_rsp.size() == 0) begin
            flag_error($sformatf("result word with nothing expected: %h", rsp_item));
         end else begin
            exp_rsp = expected_rsp.pop_front();
            if (rsp_item.cell_char !== exp_rsp.cell_char ||
                rsp_item.cell_color !== exp_rsp.cell_color ||
                rsp_item.cursor_row !== exp_rsp.cursor_row ||
                rsp_item.cursor_col !== exp_rsp.cursor_col)
               flag_error($sformatf(
                  "char %h/%h color %h/%h row %0d/%0d col %0d/%0d (expected/actual)",
                  exp_rsp.cell_char, rsp_item.cell_char,
                  exp_rsp.cell_color, rsp_item.cell_color,
                  exp_rsp.cursor_row, rsp_item.cursor_row,
                  exp_rsp.cursor_col, rsp_item.cursor_col));
         end
      end
   end

   // Watchdog: drop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [7:0] phase_color [4];
      phase_color[0] = 8'hFF;
      phase_color[1] = 8'h00;
      phase_color[2] = 8'($urandom);
      phase_color[3] = 8'($urandom);

      // Directed opening at the reset color
      queue_word(read_word(0, 0));
      queue_word(read_word(ROWS - 1, COLS - 1));
      queue_word(read_word(31, 127));
      queue_word(read_word(ROWS, 0));
      queue_word(read_word(0, COLS));
      queue_word(put_word(CH_BACKSPACE));      // backspace at the origin
      queue_word(read_word(0, 0));
      queue_word(put_word(8'h41));
      queue_word(put_word(8'h00));
      queue_word(put_word(8'hFF));
      queue_word(put_word(CH_TAB));
      queue_word(read_word(0, 5));
      queue_word(put_word(CH_NEWLINE));
      queue_word(put_word(CH_BACKSPACE));      // back to the end of the row above
      queue_word(read_word(0, COLS - 1));
      queue_word(put_word(8'h5A));             // wraps to the next row
      queue_word(read_word(0, COLS - 1));
      queue_word(put_word(8'h7F));
      queue_word(put_word(CH_BACKSPACE));
      queue_word(read_word(1, 0));
      queue_random(330);
      wait_drained(10);

      foreach (phase_color[p]) begin
         write_color(phase_color[p]);
         queue_random(325);
         wait_drained(10);
      end

      wait_drained(20);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
src/tccs_pkg.sv
src/tccs_ram.sv
src/tccs_front.sv
src/tccs_queue.sv
src/tccs_back.sv
src/text_console_cursor_scroll_core.sv
tb/text_console_cursor_scroll_core_tb.sv
